### rtl/qpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpp_pkg
// Shared constants, types and helpers for the quaternion pinhole projection.
// ----------------------------------------------------------------------------
package qpp_pkg;

	localparam int NUM_W    = 66;
	localparam int QB       = 34;
	localparam int DIV_STEPS_PER_STAGE = 2;

	localparam logic [2:0] REG_FOCAL  = 3'd0;
	localparam logic [2:0] REG_CX     = 3'd1;
	localparam logic [2:0] REG_CY     = 3'd2;
	localparam logic [2:0] REG_ASPECT = 3'd3;
	localparam logic [2:0] REG_SKEW   = 3'd4;

	// floor(a*b / 2^30) of a registered 64-bit product
	function automatic logic signed [33:0] fsh30(input logic signed [63:0] p);
		fsh30 = p[63:30];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v,
			output logic ovf);
		if (v > 36'sd2147483647) begin
			ovf = 1'b1;
			sat32 = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			ovf = 1'b1;
			sat32 = 32'sh80000000;
		end else begin
			ovf = 1'b0;
			sat32 = v[31:0];
		end
	endfunction

	typedef struct packed {
		logic [NUM_W-1:0] rem_u;
		logic [NUM_W-1:0] rem_v;
		logic [QB-1:0]    q_u;
		logic [QB-1:0]    q_v;
		logic [31:0]      zm;
		logic             neg_u;
		logic             neg_v;
		logic             nz_u;
		logic             nz_v;
		logic             zero;
		logic             bad;
	} div_t;

endpackage

### rtl/qpp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpp_divider
// Pipelined restoring divider for both numerators; two quotient bits a stage.
// ----------------------------------------------------------------------------
module qpp_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  qpp_pkg::div_t  in_word,
	output logic           out_valid,
	output qpp_pkg::div_t  out_word
);
	import qpp_pkg::*;

	localparam int NST = QB / DIV_STEPS_PER_STAGE;

	div_t st_s1 [NST+1];
	logic vl_s1 [NST+1];

	assign st_s1[0] = in_word;
	assign vl_s1[0] = in_valid;

	for (genvar g = 0; g < NST; g++) begin : g_st
		div_t nx;
		always_comb begin
			nx = st_s1[g];
			for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
				// quotient bit index
				if (nx.rem_u >= (NUM_W'({34'd0, nx.zm})
						<< (QB-1-(g*DIV_STEPS_PER_STAGE+k)))) begin
					nx.rem_u = nx.rem_u - (NUM_W'({34'd0, nx.zm})
						<< (QB-1-(g*DIV_STEPS_PER_STAGE+k)));
					nx.q_u[QB-1-(g*DIV_STEPS_PER_STAGE+k)] = 1'b1;
				end
				if (nx.rem_v >= (NUM_W'({34'd0, nx.zm})
						<< (QB-1-(g*DIV_STEPS_PER_STAGE+k)))) begin
					nx.rem_v = nx.rem_v - (NUM_W'({34'd0, nx.zm})
						<< (QB-1-(g*DIV_STEPS_PER_STAGE+k)));
					nx.q_v[QB-1-(g*DIV_STEPS_PER_STAGE+k)] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vl_s1[g+1] <= 1'b0;
			end else if (en) begin
				vl_s1[g+1] <= vl_s1[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s1[g+1] <= nx;
			end
		end
	end

	assign out_valid = vl_s1[NST];
	assign out_word  = st_s1[NST];
endmodule

### rtl/quaternion_pinhole_projection_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_pinhole_projection_core
// Rotates a point by q*(0,M)*conj(q), translates, applies intrinsics, divides.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless stalled; a single global stall freezes
// the math and divider stages, but not the output register.
// The 34-bit quotient takes 17 two-bit divider stages after 8 math stages,
// then one output register.
// Reset: config returns to f=1.0, ar=1.0, others 0; all valid bits clear.
module quaternion_pinhole_projection_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] rot_w,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] image_u,
	output logic signed [31:0] image_v,
	output logic               bad_projection
);
	import qpp_pkg::*;

	logic [30:0]        focal_q, aspect_q;
	logic signed [31:0] cx_q, cy_q, skew_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= 31'd65536;
			cx_q     <= '0;
			cy_q     <= '0;
			aspect_q <= 31'd16777216;
			skew_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL:  focal_q  <= cfg_data[30:0];
				REG_CX:     cx_q     <= cfg_data;
				REG_CY:     cy_q     <= cfg_data;
				REG_ASPECT: aspect_q <= cfg_data[30:0];
				REG_SKEW:   skew_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register with skid
	logic       en;
	logic       ov_q, sk_v_q;
	logic [64:0] ob_q, sk_q;
	logic       dv;
	logic [64:0] dw;
	assign en       = !sk_v_q;
	assign in_stall = sk_v_q;

	// stage 1: products of q and M
	logic v1, v2, v3, v4, v5, v6, v7, v8;
	logic signed [31:0] w1, x1, y1, z1, tx1, ty1, tz1;
	logic signed [63:0] m1 [12];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
		end else if (en) begin
			{v1, v2, v3, v4, v5, v6, v7, v8} <= {in_valid, v1, v2, v3, v4, v5, v6, v7};
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			w1 <= rot_w; x1 <= rot_x; y1 <= rot_y; z1 <= rot_z;
			tx1 <= shift_x; ty1 <= shift_y; tz1 <= shift_z;
			m1[0]  <= rot_x * point_x; m1[1]  <= rot_y * point_y;
			m1[2]  <= rot_z * point_z; m1[3]  <= rot_w * point_x;
			m1[4]  <= rot_y * point_z; m1[5]  <= rot_z * point_y;
			m1[6]  <= rot_w * point_y; m1[7]  <= rot_z * point_x;
			m1[8]  <= rot_x * point_z; m1[9]  <= rot_w * point_z;
			m1[10] <= rot_x * point_y; m1[11] <= rot_y * point_x;
		end
	end

	// stage 2: first rotation sums, saturate
	logic signed [31:0] w2, x2, y2, z2, tx2, ty2, tz2, ps2, pa2, pb2, pc2;
	logic b2;
	always_ff @(posedge clk) begin
		logic o0, o1, o2, o3;
		if (en) begin
			ps2 <= sat32(36'(-(36'(fsh30(m1[0])) + fsh30(m1[1]) + fsh30(m1[2]))), o0);
			pa2 <= sat32(36'(fsh30(m1[3])) + fsh30(m1[4]) - fsh30(m1[5]), o1);
			pb2 <= sat32(36'(fsh30(m1[6])) + fsh30(m1[7]) - fsh30(m1[8]), o2);
			pc2 <= sat32(36'(fsh30(m1[9])) + fsh30(m1[10]) - fsh30(m1[11]), o3);
			b2 <= o0 | o1 | o2 | o3;
			w2 <= w1; x2 <= x1; y2 <= y1; z2 <= z1;
			tx2 <= tx1; ty2 <= ty1; tz2 <= tz1;
		end
	end

	// stage 3: second rotation products
	logic signed [63:0] m3 [12];
	logic signed [31:0] tx3, ty3, tz3;
	logic b3;
	always_ff @(posedge clk) begin
		if (en) begin
			m3[0] <= x2 * ps2; m3[1] <= w2 * pa2; m3[2]  <= z2 * pb2; m3[3]  <= y2 * pc2;
			m3[4] <= y2 * ps2; m3[5] <= w2 * pb2; m3[6]  <= x2 * pc2; m3[7]  <= z2 * pa2;
			m3[8] <= z2 * ps2; m3[9] <= w2 * pc2; m3[10] <= y2 * pa2; m3[11] <= x2 * pb2;
			tx3 <= tx2; ty3 <= ty2; tz3 <= tz2; b3 <= b2;
		end
	end

	// stage 4: camera coordinates; fy product
	logic signed [31:0] cxv4, cyv4, czv4;
	logic [61:0] fa4;
	logic b4;
	always_ff @(posedge clk) begin
		logic o0, o1, o2;
		if (en) begin
			cxv4 <= sat32(36'(tx3) - fsh30(m3[0]) + fsh30(m3[1]) - fsh30(m3[2])
				+ fsh30(m3[3]), o0);
			cyv4 <= sat32(36'(ty3) - fsh30(m3[4]) + fsh30(m3[5]) - fsh30(m3[6])
				+ fsh30(m3[7]), o1);
			czv4 <= sat32(36'(tz3) - fsh30(m3[8]) + fsh30(m3[9]) - fsh30(m3[10])
				+ fsh30(m3[11]), o2);
			fa4 <= focal_q * aspect_q;
			b4 <= b3 | o0 | o1 | o2;
		end
	end

	// stage 5: fy saturate
	logic signed [31:0] cxv5, cyv5, czv5;
	logic [30:0] fy5;
	logic b5;
	always_ff @(posedge clk) begin
		if (en) begin
			fy5 <= (fa4[61:55] != '0) ? 31'h7fffffff : fa4[54:24];
			b5 <= b4 | (fa4[61:55] != '0);
			cxv5 <= cxv4; cyv5 <= cyv4; czv5 <= czv4;
		end
	end

	// stage 6: numerator products
	logic signed [63:0] n6 [5];
	logic signed [31:0] czv6;
	logic b6;
	always_ff @(posedge clk) begin
		if (en) begin
			n6[0] <= $signed({1'b0, focal_q}) * cxv5;
			n6[1] <= skew_q * cyv5;
			n6[2] <= cx_q * czv5;
			n6[3] <= $signed({1'b0, fy5}) * cyv5;
			n6[4] <= cy_q * czv5;
			czv6 <= czv5; b6 <= b5;
		end
	end

	// stage 7: numerator sums
	logic signed [65:0] nu7, nv7;
	logic signed [31:0] czv7;
	logic b7;
	always_ff @(posedge clk) begin
		if (en) begin
			nu7 <= 66'(n6[0]) + 66'(n6[1]) + 66'(n6[2]);
			nv7 <= 66'(n6[3]) + 66'(n6[4]);
			czv7 <= czv6; b7 <= b6;
		end
	end

	// stage 8: magnitudes
	div_t d8;
	always_ff @(posedge clk) begin
		if (en) begin
			d8.rem_u <= nu7[65] ? 66'(-nu7) : nu7;
			d8.rem_v <= nv7[65] ? 66'(-nv7) : nv7;
			d8.q_u <= '0; d8.q_v <= '0;
			d8.zm <= czv7[31] ? 32'(-czv7) : czv7;
			d8.neg_u <= nu7[65] ^ czv7[31];
			d8.neg_v <= nv7[65] ^ czv7[31];
			d8.nz_u <= nu7 != '0;
			d8.nz_v <= nv7 != '0;
			d8.zero <= czv7 == '0;
			d8.bad <= b7;
		end
	end

	div_t dq;
	logic dqv;
	qpp_divider u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v8), .in_word(d8),
		.out_valid(dqv), .out_word(dq)
	);

	// final saturation
	always_comb begin
		logic su, sv;
		logic signed [31:0] u, v;
		if (dq.zero) begin
			u = !dq.nz_u ? '0 : (dq.neg_u ? 32'sh80000000 : 32'sh7fffffff);
			v = !dq.nz_v ? '0 : (dq.neg_v ? 32'sh80000000 : 32'sh7fffffff);
			su = 1'b1; sv = 1'b0;
		end else begin
			if (dq.neg_u) begin
				su = dq.q_u > 34'h80000000;
				u = su ? 32'sh80000000 : 32'(-dq.q_u);
			end else begin
				su = dq.q_u > 34'h7fffffff;
				u = su ? 32'sh7fffffff : dq.q_u[31:0];
			end
			if (dq.neg_v) begin
				sv = dq.q_v > 34'h80000000;
				v = sv ? 32'sh80000000 : 32'(-dq.q_v);
			end else begin
				sv = dq.q_v > 34'h7fffffff;
				v = sv ? 32'sh7fffffff : dq.q_v[31:0];
			end
		end
		dv = dqv;
		dw = {u, v, dq.bad | su | sv};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else begin
			if (!ov_q || !out_stall) begin
				ov_q <= sk_v_q ? 1'b1 : dv;
				sk_v_q <= 1'b0;
			end else if (en && dv) begin
				sk_v_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (!ov_q || !out_stall) begin
			ob_q <= sk_v_q ? sk_q : dw;
		end else if (en && dv) begin
			sk_q <= dw;
		end
	end

	assign out_valid      = ov_q;
	assign image_u        = ob_q[64:33];
	assign image_v        = ob_q[32:1];
	assign bad_projection = ob_q[0];
endmodule
